@@ rtl/flt_pkg.sv @@
// Shared types, token kinds and the keyword table of the tokenizer.
// No dependencies; every other file of the block imports this package.
package flt_pkg;

	localparam int NUM_KEYS = 26;
	localparam int KEY_CHARS = 7;

	localparam logic [5:0] K_EOF   = 6'd0;
	localparam logic [5:0] K_ADD   = 6'd1;
	localparam logic [5:0] K_SUB   = 6'd2;
	localparam logic [5:0] K_ARROW = 6'd3;
	localparam logic [5:0] K_MUL   = 6'd4;
	localparam logic [5:0] K_DIV   = 6'd5;
	localparam logic [5:0] K_INT   = 6'd6;
	localparam logic [5:0] K_IDENT = 6'd7;
	localparam logic [5:0] K_KEY0  = 6'd8;
	localparam logic [5:0] K_OTHER = 6'd34;

	localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [30:0] int_value;
		logic [7:0]  raw_char;
		logic [31:0] line_number;
		logic [31:0] token_start;
		logic [7:0]  token_length;
		logic        last_result;
	} out_item_t;

	// Per-character control broadcast to every keyword cell.
	typedef struct packed {
		logic       start;
		logic       add;
		logic [7:0] ch;
		logic [7:0] pos;
	} kw_ctl_t;

	// Keyword text, first character in the top byte, zero padded.
	function automatic logic [55:0] key_word(input logic [4:0] k);
		logic [55:0] w;
		case (k)
			5'd0:  w = {"and", 32'd0};
			5'd1:  w = {"apndl", 16'd0};
			5'd2:  w = {"apndr", 16'd0};
			5'd3:  w = {"atom", 24'd0};
			5'd4:  w = {"concat", 8'd0};
			5'd5:  w = {"distl", 16'd0};
			5'd6:  w = {"distr", 16'd0};
			5'd7:  w = {"eq", 40'd0};
			5'd8:  w = {"ge", 40'd0};
			5'd9:  w = {"gt", 40'd0};
			5'd10: w = {"id", 40'd0};
			5'd11: w = {"le", 40'd0};
			5'd12: w = {"length", 8'd0};
			5'd13: w = {"lt", 40'd0};
			5'd14: w = {"ne", 40'd0};
			5'd15: w = {"not", 32'd0};
			5'd16: w = {"null", 24'd0};
			5'd17: w = {"or", 40'd0};
			5'd18: w = {"out", 32'd0};
			5'd19: w = {"pair", 24'd0};
			5'd20: w = "reverse";
			5'd21: w = {"rotl", 24'd0};
			5'd22: w = {"rotr", 24'd0};
			5'd23: w = {"split", 16'd0};
			5'd24: w = {"tl", 40'd0};
			5'd25: w = {"trans", 16'd0};
			default: w = 56'd0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] key_len(input logic [4:0] k);
		logic [2:0] n;
		case (k)
			5'd0, 5'd15, 5'd18:                      n = 3'd3;
			5'd1, 5'd2, 5'd5, 5'd6, 5'd23, 5'd25:   n = 3'd5;
			5'd3, 5'd16, 5'd19, 5'd21, 5'd22:       n = 3'd4;
			5'd4, 5'd12:                            n = 3'd6;
			5'd20:                                  n = 3'd7;
			default:                                n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] key_char(input logic [4:0] k, input logic [2:0] p);
		logic [55:0] w;
		w = key_word(k) << {p, 3'b000};
		return w[55:48];
	endfunction

endpackage

@@ rtl/flt_kw_cell.sv @@
// One keyword cell: tracks whether the name so far is a prefix of its keyword.
// Depends on flt_pkg; a row of these is built by the top level.
module flt_kw_cell import flt_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  kw_ctl_t    ctl,
	input  logic [7:0] name_len,
	input  logic [5:0] kind_in,
	output logic [5:0] kind_out
);

	localparam logic [4:0] KIDX = 5'(INDEX);
	localparam logic [2:0] KLEN = key_len(KIDX);

	logic match_q;
	logic char_ok;

	assign char_ok = (ctl.pos < {5'd0, KLEN}) && (key_char(KIDX, ctl.pos[2:0]) == ctl.ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b1;
		end else if (ctl.start) begin
			match_q <= (key_char(KIDX, 3'd0) == ctl.ch);
		end else if (ctl.add) begin
			match_q <= match_q & char_ok;
		end
	end

	// The kind ripples along the row; a full match replaces what came in.
	assign kind_out = (match_q && (name_len == {5'd0, KLEN})) ? 6'(K_KEY0 + KIDX) : kind_in;

endmodule

@@ rtl/flt_result_fifo.sv @@
// Four-entry result queue that takes up to two results a cycle and gives one.
// Depends on flt_pkg for the result type.
module flt_result_fifo import flt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] push_n,
	input  out_item_t push_a,
	input  out_item_t push_b,
	output logic      has_room,
	output logic      token_valid,
	input  logic      token_ready,
	output out_item_t token_item
);

	out_item_t   mem [4];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  count_q;
	logic        pop;

	assign pop         = token_valid & token_ready;
	assign token_valid = (count_q != 3'd0);
	assign token_item  = mem[rd_q];
	assign has_room    = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem[wr_q + 2'd1] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + push_n;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_n} - {2'd0, pop};
		end
	end

endmodule

@@ rtl/functional_language_tokenizer_unit.sv @@
// Character tokenizer: one byte (or end mark) per transaction in, tokens out.
// Results of a character are written into the result queue when it is taken and offered from there in order.
// Throughput: one character per cycle; input ready drops while the four-entry
// result queue has fewer than two free slots, so output drain sets the rate.
// Reset: asynchronous, clears the scanner to idle, line 1, position 0, queue empty.
module functional_language_tokenizer_unit import flt_pkg::*; #(
	parameter int MAX_NAME_LEN = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      token_valid,
	input  logic      token_ready,
	output out_item_t token_item
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_MINUS   = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_NUMBER  = 3'd3;
	localparam logic [2:0] MODE_IDENT   = 3'd4;
	localparam logic [7:0] NAME_MAX     = 8'(MAX_NAME_LEN);

	logic [2:0]  mode_q;
	logic [30:0] accum_q;
	logic [7:0]  name_len_q;
	logic [31:0] line_q;
	logic [31:0] pos_q;
	logic [31:0] start_q;

	logic        acc;
	logic [7:0]  c;
	logic        eoi;
	logic        is_digit, is_alpha, is_head, is_tail, is_space, is_nl;
	logic [5:0]  kw_kind;
	logic [5:0]  kind_chain [NUM_KEYS+1];
	kw_ctl_t     kw_ctl;

	// Classification of the character as the start of a new token.
	logic        f_put;
	logic [5:0]  f_kind;
	logic [2:0]  f_mode;

	logic        do_fresh, flush, arrow, num_cont, id_cont, inc_line;
	logic [2:0]  mode_n;
	logic [34:0] num_next;
	out_item_t   res_a, res_b, push_a, push_b;
	logic        a_v, b_v;
	logic [1:0]  push_n;
	logic        has_room;

	assign c   = char_item.char_code;
	assign eoi = char_item.end_of_input;
	assign acc = char_valid & char_ready;
	assign char_ready = has_room;

	assign is_digit = (c >= "0") && (c <= "9");
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_head  = is_alpha || (c == "_") || (c == "?");
	assign is_tail  = is_head || is_digit;
	assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	assign is_nl    = (c == 8'd10);

	always_comb begin
		f_put  = 1'b1;
		f_kind = K_OTHER;
		f_mode = MODE_IDLE;
		if (is_space) begin
			f_put = 1'b0;
		end else if (c == "+") begin
			f_kind = K_ADD;
		end else if (c == "-") begin
			f_put  = 1'b0;
			f_mode = MODE_MINUS;
		end else if (c == "*") begin
			f_kind = K_MUL;
		end else if (c == "/") begin
			f_kind = K_DIV;
		end else if (is_digit) begin
			f_put  = 1'b0;
			f_mode = MODE_NUMBER;
		end else if (is_head) begin
			f_put  = 1'b0;
			f_mode = MODE_IDENT;
		end
	end

	always_comb begin
		do_fresh = 1'b0;
		flush    = 1'b0;
		arrow    = 1'b0;
		num_cont = 1'b0;
		id_cont  = 1'b0;
		mode_n   = mode_q;
		if (eoi) begin
			flush  = (mode_q == MODE_MINUS) || (mode_q == MODE_NUMBER) ||
			         (mode_q == MODE_IDENT);
			mode_n = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_MINUS: begin
					if (c == ">") begin
						arrow  = 1'b1;
						mode_n = MODE_IDLE;
					end else if (c == "-") begin
						mode_n = MODE_COMMENT;
					end else begin
						flush    = 1'b1;
						do_fresh = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (is_nl) begin
						mode_n = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						num_cont = 1'b1;
					end else begin
						flush    = 1'b1;
						do_fresh = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_tail) begin
						id_cont = 1'b1;
					end else begin
						flush    = 1'b1;
						do_fresh = 1'b1;
					end
				end
				default: begin
					do_fresh = 1'b1;
				end
			endcase
			if (do_fresh) begin
				mode_n = f_mode;
			end
		end
	end

	assign inc_line = !eoi && is_nl && (do_fresh || (mode_q == MODE_COMMENT));
	assign num_next = {4'd0, accum_q} * 35'd10 + {27'd0, c - 8'h30};

	// Keyword cells: a row that ripples the matching kind from cell to cell.
	assign kw_ctl.start = acc && do_fresh && (f_mode == MODE_IDENT);
	assign kw_ctl.add   = acc && id_cont;
	assign kw_ctl.ch    = c;
	assign kw_ctl.pos   = name_len_q;
	assign kind_chain[0] = K_IDENT;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_kw
		flt_kw_cell #(.INDEX(k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (kw_ctl),
			.name_len(name_len_q),
			.kind_in (kind_chain[k]),
			.kind_out(kind_chain[k+1])
		);
	end
	assign kw_kind = kind_chain[NUM_KEYS];

	// First result: the pending token that this character ends, or an arrow.
	always_comb begin
		res_a              = '0;
		res_a.line_number  = line_q;
		res_a.token_start  = start_q;
		res_a.token_length = 8'd1;
		if (arrow) begin
			res_a.token_kind   = K_ARROW;
			res_a.token_length = 8'd2;
		end else begin
			case (mode_q)
				MODE_NUMBER: begin
					res_a.token_kind   = K_INT;
					res_a.int_value    = accum_q;
					res_a.token_length = name_len_q;
				end
				MODE_IDENT: begin
					res_a.token_kind   = kw_kind;
					res_a.token_length = name_len_q;
				end
				default: begin
					res_a.token_kind = K_SUB;
				end
			endcase
		end
		a_v = flush || arrow;

		res_b              = '0;
		res_b.line_number  = line_q;
		res_b.token_start  = pos_q;
		res_b.last_result  = 1'b1;
		if (eoi) begin
			res_b.token_kind   = K_EOF;
			res_b.token_length = 8'd0;
		end else begin
			res_b.token_kind   = f_kind;
			res_b.token_length = 8'd1;
			res_b.raw_char     = (f_kind == K_OTHER) ? c : 8'd0;
		end
		b_v = eoi || (do_fresh && f_put);
		res_a.last_result = !b_v;
	end

	always_comb begin
		push_a = a_v ? res_a : res_b;
		push_b = res_b;
		push_n = 2'd0;
		if (acc) begin
			push_n = {1'b0, a_v} + {1'b0, b_v};
		end
	end

	flt_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_a     (push_a),
		.push_b     (push_b),
		.has_room   (has_room),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_item (token_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			accum_q    <= '0;
			name_len_q <= '0;
			line_q     <= 32'd1;
			pos_q      <= '0;
			start_q    <= '0;
		end else if (acc) begin
			mode_q <= mode_n;
			if (!eoi) begin
				pos_q <= pos_q + 32'd1;
			end
			if (inc_line && (line_q != 32'hFFFF_FFFF)) begin
				line_q <= line_q + 32'd1;
			end
			if (do_fresh && (f_mode != MODE_IDLE)) begin
				start_q <= pos_q;
			end
			if (do_fresh && (f_mode == MODE_NUMBER)) begin
				accum_q    <= {23'd0, c - 8'h30};
				name_len_q <= 8'd1;
			end else if (do_fresh && (f_mode == MODE_IDENT)) begin
				name_len_q <= 8'd1;
			end else if (num_cont) begin
				accum_q <= (num_next > {4'd0, INT_SAT}) ? INT_SAT : num_next[30:0];
				if (name_len_q != 8'hFF) begin
					name_len_q <= name_len_q + 8'd1;
				end
			end else if (id_cont) begin
				if (name_len_q < NAME_MAX) begin
					name_len_q <= name_len_q + 8'd1;
				end
			end
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for functional_language_tokenizer_unit: feeds character streams, predicts
// every token in a scanner model of its own and checks each output transaction in order.
// Depends on flt_pkg for the transaction structs and the token kind constants.
module testbench;
	import flt_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int NAME_MAX = 255;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_MINUS, SCAN_COMMENT, SCAN_NUMBER, SCAN_NAME
	} scan_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_ready;
	in_item_t  char_item = '0;
	logic      token_valid;
	logic      token_ready = 1'b0;
	out_item_t token_item;

	// Scanner state of the predictor.
	scan_t       scan_state = SCAN_IDLE;
	logic [30:0] num_value = '0;
	logic [7:0]  tok_len = '0;
	logic [7:0]  name_chars [8];
	logic [31:0] line_no = 32'd1;
	logic [31:0] stream_pos = '0;
	logic [31:0] tok_pos = '0;

	string keyword_text [NUM_KEYS] = '{
		"and", "apndl", "apndr", "atom", "concat", "distl", "distr", "eq",
		"ge", "gt", "id", "le", "length", "lt", "ne", "not", "null", "or",
		"out", "pair", "reverse", "rotl", "rotr", "split", "tl", "trans"
	};

	out_item_t step_tokens [$];
	out_item_t expected_tokens [$];

	int       mismatches = 0;
	int       cycle_count = 0;
	int       max_gap = 0;
	int       burst_left = 0;
	int       hold_count = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	logic [7:0] stall_pattern = 8'b1011_0110;

	functional_language_tokenizer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_item(token_item)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_name_head(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "?";
	endfunction

	function automatic bit is_name_tail(input logic [7:0] c);
		return is_name_head(c) || is_digit(c);
	endfunction

	function automatic void push_token(input logic [5:0] kind, input logic [30:0] ival,
			input logic [7:0] raw, input logic [31:0] start, input logic [7:0] len);
		out_item_t t;
		t.token_kind = kind;
		t.int_value = ival;
		t.raw_char = raw;
		t.line_number = line_no;
		t.token_start = start;
		t.token_length = len;
		t.last_result = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void bump_line();
		if (line_no != '1)
			line_no++;
	endfunction

	function automatic void name_add(input logic [7:0] c);
		if (tok_len < 8)
			name_chars[tok_len] = c;
		if (tok_len < NAME_MAX)
			tok_len++;
	endfunction

	// A name is a keyword only when its full text equals one entry of the table.
	function automatic logic [5:0] name_kind();
		logic [5:0] kind;
		bit same;
		kind = K_IDENT;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (keyword_text[k].len() == tok_len) begin
				same = 1'b1;
				for (int i = 0; i < keyword_text[k].len(); i++)
					if (keyword_text[k][i] != name_chars[i])
						same = 1'b0;
				if (same)
					kind = K_KEY0 + 6'(k);
			end
		end
		return kind;
	endfunction

	function automatic void scan_start(input logic [7:0] c, input logic [31:0] p);
		scan_state = SCAN_IDLE;
		if (is_blank(c)) begin
			if (c == CH_NEWLINE)
				bump_line();
		end else if (c == "+") begin
			push_token(K_ADD, 0, 0, p, 1);
		end else if (c == "-") begin
			scan_state = SCAN_MINUS;
			tok_pos = p;
		end else if (c == "*") begin
			push_token(K_MUL, 0, 0, p, 1);
		end else if (c == "/") begin
			push_token(K_DIV, 0, 0, p, 1);
		end else if (is_digit(c)) begin
			scan_state = SCAN_NUMBER;
			tok_pos = p;
			num_value = 31'(c - 8'h30);
			tok_len = 8'd1;
		end else if (is_name_head(c)) begin
			scan_state = SCAN_NAME;
			tok_pos = p;
			tok_len = '0;
			name_add(c);
		end else begin
			push_token(K_OTHER, 0, c, p, 1);
		end
	endfunction

	// Advances the predictor by one accepted transaction and queues its tokens.
	function automatic void scan_item(input in_item_t it);
		logic [7:0]  c;
		logic [31:0] p;
		logic [34:0] wide;
		out_item_t   t;
		c = it.char_code;
		p = stream_pos;
		step_tokens.delete();
		if (it.end_of_input) begin
			case (scan_state)
				SCAN_MINUS: push_token(K_SUB, 0, 0, tok_pos, 1);
				SCAN_NUMBER: push_token(K_INT, num_value, 0, tok_pos, tok_len);
				SCAN_NAME: push_token(name_kind(), 0, 0, tok_pos, tok_len);
				default: ;
			endcase
			push_token(K_EOF, 0, 0, p, 0);
			scan_state = SCAN_IDLE;
		end else begin
			case (scan_state)
				SCAN_MINUS: begin
					if (c == ">") begin
						push_token(K_ARROW, 0, 0, tok_pos, 2);
						scan_state = SCAN_IDLE;
					end else if (c == "-") begin
						scan_state = SCAN_COMMENT;
					end else begin
						push_token(K_SUB, 0, 0, tok_pos, 1);
						scan_start(c, p);
					end
				end
				SCAN_COMMENT: begin
					if (c == CH_NEWLINE) begin
						bump_line();
						scan_state = SCAN_IDLE;
					end
				end
				SCAN_NUMBER: begin
					if (is_digit(c)) begin
						wide = 35'(num_value) * 35'd10 + 35'(c - 8'h30);
						num_value = (wide > 35'(INT_SAT)) ? INT_SAT : wide[30:0];
						if (tok_len != 8'hFF)
							tok_len++;
					end else begin
						push_token(K_INT, num_value, 0, tok_pos, tok_len);
						scan_start(c, p);
					end
				end
				SCAN_NAME: begin
					if (is_name_tail(c)) begin
						name_add(c);
					end else begin
						push_token(name_kind(), 0, 0, tok_pos, tok_len);
						scan_start(c, p);
					end
				end
				default: scan_start(c, p);
			endcase
			stream_pos = p + 32'd1;
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens.pop_back();
			t.last_result = 1'b1;
			step_tokens.push_back(t);
		end
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void compare_token(input out_item_t want, input out_item_t got);
		if (got.token_kind !== want.token_kind) begin
			$error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
			mismatches++;
		end
		if (got.int_value !== want.int_value) begin
			$error("int_value: expected %0d, got %0d", want.int_value, got.int_value);
			mismatches++;
		end
		if (got.raw_char !== want.raw_char) begin
			$error("raw_char: expected %0d, got %0d", want.raw_char, got.raw_char);
			mismatches++;
		end
		if (got.line_number !== want.line_number) begin
			$error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
			mismatches++;
		end
		if (got.token_start !== want.token_start) begin
			$error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
			mismatches++;
		end
		if (got.token_length !== want.token_length) begin
			$error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
			mismatches++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && token_valid === 1'b1 && token_ready) begin
			if (expected_tokens.size() == 0) begin
				$error("token transaction with no expectation: kind %0d", token_item.token_kind);
				mismatches++;
			end else begin
				compare_token(expected_tokens.pop_front(), token_item);
			end
		end
	end

	// Token receiver. In hold mode it stalls for a long stretch, then drains at full rate.
	always @(posedge clk) begin
		if (rx_mode == RX_HOLD) begin
			token_ready <= (hold_count >= HOLD_CYCLES);
			if (hold_count < HOLD_CYCLES)
				hold_count++;
		end else begin
			hold_count = 0;
			case (rx_mode)
				RX_ALWAYS: token_ready <= 1'b1;
				RX_RANDOM: token_ready <= ($urandom_range(0, 3) != 0);
				default: begin
					token_ready <= stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timed out with %0d tokens outstanding", expected_tokens.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one character transaction; while max_gap is nonzero the sender pauses between bursts of random length.
	task automatic send_char(input logic [7:0] c, input logic eoi);
		in_item_t it;
		it.char_code = c;
		it.end_of_input = eoi;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (max_gap > 0) begin
				char_valid <= 1'b0;
				repeat ($urandom_range(1, max_gap)) @(posedge clk);
			end
		end
		char_item <= it;
		char_valid <= 1'b1;
		do @(posedge clk); while (!char_ready);
		burst_left--;
		scan_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_name_char(input bit head);
		int r;
		r = $urandom_range(0, head ? 53 : 63);
		if (r < 26)
			return 8'h61 + 8'(r);
		else if (r < 52)
			return 8'h41 + 8'(r - 26);
		else if (r == 52)
			return "_";
		else if (r == 53)
			return "?";
		return 8'h30 + 8'(r - 54);
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 5))
			0: return " ";
			1: return 8'h09;
			2: return CH_NEWLINE;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return 8'h0D;
		endcase
	endfunction

	task automatic test_operators();
		// A minus followed by anything but > or - yields sub and then rescans that char.
		send_text("+ *\t/->-+");
	endtask

	task automatic test_words();
		send_text("and 7,x?");
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_comments();
		send_text("--\n");
		send_text("--");
		send_char(8'hFF, 1'b1);
	endtask

	task automatic test_raw_bytes();
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_char("-", 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	task automatic test_long_tokens();
		send_char("9", 1'b0);
		repeat (259) send_char(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
		send_char(" ", 1'b0);
		send_text("reverse");
		repeat (253) send_char(random_name_char(1'b0), 1'b0);
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_random_stream(input int item_goal);
		int    made;
		int    pick;
		int    n;
		string w;
		made = 0;
		while (made < item_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				w = keyword_text[$urandom_range(0, NUM_KEYS - 1)];
				send_text(w);
				made += w.len();
			end else if (pick < 30) begin
				w = keyword_text[$urandom_range(0, NUM_KEYS - 1)];
				if ($urandom_range(0, 1)) begin
					w = w.substr(0, w.len() - 2);
					send_text(w);
					made += w.len();
				end else begin
					send_text(w);
					send_char(random_name_char(1'b0), 1'b0);
					made += w.len() + 1;
				end
			end else if (pick < 40) begin
				n = $urandom_range(1, 12);
				send_char(random_name_char(1'b1), 1'b0);
				repeat (n - 1) send_char(random_name_char(1'b0), 1'b0);
				made += n;
			end else if (pick < 55) begin
				n = $urandom_range(1, 14);
				repeat (n) send_char(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
				made += n;
			end else if (pick < 67) begin
				case ($urandom_range(0, 4))
					0: send_text("+");
					1: send_text("-");
					2: send_text("*");
					3: send_text("/");
					default: send_text("->");
				endcase
				made++;
			end else if (pick < 73) begin
				send_text("--");
				repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(0, 255)), 1'b0);
				send_char(CH_NEWLINE, 1'b0);
			end else if (pick < 88) begin
				send_char(8'($urandom_range(0, 255)), 1'b0);
				made++;
			end else if (pick < 93) begin
				send_char(8'($urandom_range(0, 255)), 1'b1);
				made++;
			end else begin
				send_char(CH_NEWLINE, 1'b0);
			end
			if ($urandom_range(0, 9) < 6)
				send_char(random_blank(), 1'b0);
		end
	endtask

	task automatic test_backpressure();
		rx_mode = RX_HOLD;
		max_gap = 0;
		repeat (12) send_text("12+ab*");
		// The last transaction has been taken, so stop offering it while the queue drains.
		char_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		rx_mode = RX_ALWAYS;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		rx_mode = RX_ALWAYS;
		max_gap = 0;
		test_operators();
		test_words();
		test_comments();
		test_raw_bytes();

		rx_mode = RX_RANDOM;
		max_gap = 6;
		test_long_tokens();
		test_random_stream(250);

		rx_mode = RX_PATTERN;
		max_gap = 0;
		test_random_stream(250);

		test_backpressure();

		rx_mode = RX_RANDOM;
		max_gap = 3;
		test_random_stream(250);

		char_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/flt_pkg.sv
rtl/flt_kw_cell.sv
rtl/flt_result_fifo.sv
rtl/functional_language_tokenizer_unit.sv
bench/testbench.sv
